// File: hdl/crip_pkg.sv
package crip_pkg;

    localparam int REG_STOPS = 6;
    localparam int STOP_W    = 56;
    localparam int POS_W     = 32;
    localparam int RGB_W     = 24;
    localparam int COUNT_W   = 3;
    localparam int ALPHA_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int STOP_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_COUNT  = 3'd0,
        REG_ALPHA_LEVEL = 3'd1,
        REG_STOP_ZERO   = 3'd2,
        REG_STOP_ONE    = 3'd3,
        REG_STOP_TWO    = 3'd4,
        REG_STOP_THREE  = 3'd5,
        REG_STOP_FOUR   = 3'd6,
        REG_STOP_FIVE   = 3'd7
    } t_cfg_reg;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd5;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'd255;

    typedef logic [STOP_W-1:0] t_stop;

    localparam t_stop STOP_RESET [REG_STOPS] = '{
        56'd255,
        56'd274877972479,
        56'd549755879168,
        56'd824650497792,
        56'd1099528339456,
        56'd0
    };

    // colors and the zero flag that ride along with the divider
    typedef struct packed {
        logic             zero;
        logic [RGB_W-1:0] c0;
        logic [RGB_W-1:0] c1;
    } t_side;

endpackage

// File: hdl/crip_divider.sv
module crip_divider #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [32:0]             i_num,
    input  logic [32:0]             i_den,
    input  crip_pkg::t_side         i_side,
    output logic                    o_valid,
    output logic [FRACTION_BITS:0]  o_quot,
    output crip_pkg::t_side         o_side
);
    import crip_pkg::*;

    localparam int STAGES = FRACTION_BITS + 1;

    logic                   r_v    [STAGES];
    logic [33:0]            r_rem  [STAGES];
    logic [32:0]            r_den  [STAGES];
    logic [FRACTION_BITS:0] r_q    [STAGES];
    t_side                  r_side [STAGES];

    // one quotient bit per stage, restoring
    for (genvar t = 0; t < STAGES; t++) begin : g_stage
        logic [33:0]            w_rem_in;
        logic [32:0]            w_den_in;
        logic [FRACTION_BITS:0] w_q_in;
        logic [33:0]            w_trial;
        logic [33:0]            n_rem;
        logic [FRACTION_BITS:0] n_q;
        logic                   w_v_in;
        t_side                  w_side_in;

        if (t == 0) begin : g_first
            assign w_rem_in  = {1'b0, i_num};
            assign w_den_in  = i_den;
            assign w_q_in    = '0;
            assign w_v_in    = i_valid;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_rem_in  = {r_rem[t-1][32:0], 1'b0};
            assign w_den_in  = r_den[t-1];
            assign w_q_in    = r_q[t-1];
            assign w_v_in    = r_v[t-1];
            assign w_side_in = r_side[t-1];
        end

        always_comb begin
            w_trial = w_rem_in - {1'b0, w_den_in};
            if (w_rem_in >= {1'b0, w_den_in}) begin
                n_rem = w_trial;
                n_q   = {w_q_in[FRACTION_BITS-1:0], 1'b1};
            end else begin
                n_rem = w_rem_in;
                n_q   = {w_q_in[FRACTION_BITS-1:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[t] <= 1'b0;
            end else if (i_en) begin
                r_v[t] <= w_v_in;
            end
            if (i_en) begin
                r_rem[t]  <= n_rem;
                r_den[t]  <= w_den_in;
                r_q[t]    <= n_q;
                r_side[t] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_quot  = r_q[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule

// File: hdl/color_ramp_interpolator.sv
// color ramp interpolator: maps a signed q16.16 sample to an rgba word
// through up to six configured color stops, blending linearly between
// the two stops around the sample.
// input channel: i_valid / o_ready with i_sample. output channel:
// o_valid / i_ready with o_red, o_green, o_blue, o_alpha_out.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_index;
// write only while no word is in flight.
// throughput: one word per cycle while the output word is not held. the
// divider resolves one quotient bit per pipeline stage and sits between
// the input, compare and select stages and the blend stage.
// the whole pipeline advances as one: when the output word is held
// (o_valid high, i_ready low) every stage holds and o_ready drops, so
// nothing is lost or repeated.
// reset clears all valid bits and restores the default five-stop
// blue-cyan-green-yellow-red ramp over 0 to 1 with alpha 255.
module color_ramp_interpolator #(
    parameter int MAX_STOPS     = 6,
    parameter int FRACTION_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [31:0]                 i_sample,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    output logic [7:0]                         o_alpha_out,
    input  logic                               i_cfg_we,
    input  logic [crip_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [crip_pkg::STOP_W-1:0]        i_cfg_data
);
    import crip_pkg::*;

    localparam int ACC_W = FRACTION_BITS + 10;

    // configuration registers
    logic [COUNT_W-1:0] r_count;
    logic [ALPHA_W-1:0] r_alpha;
    t_stop              r_stop [REG_STOPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
            r_alpha <= ALPHA_RESET;
            for (int k = 0; k < REG_STOPS; k++) r_stop[k] <= STOP_RESET[k];
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_STOP_COUNT:  r_count <= i_cfg_data[COUNT_W-1:0];
                REG_ALPHA_LEVEL: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                REG_STOP_ZERO:   r_stop[0] <= i_cfg_data;
                REG_STOP_ONE:    r_stop[1] <= i_cfg_data;
                REG_STOP_TWO:    r_stop[2] <= i_cfg_data;
                REG_STOP_THREE:  r_stop[3] <= i_cfg_data;
                REG_STOP_FOUR:   r_stop[4] <= i_cfg_data;
                REG_STOP_FIVE:   r_stop[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [POS_W-1:0] w_pos [REG_STOPS];
    logic [COUNT_W-1:0]      w_n;
    logic [STOP_IDX_W-1:0]   w_last;

    always_comb begin
        for (int k = 0; k < REG_STOPS; k++) w_pos[k] = r_stop[k][STOP_W-1:RGB_W];
        w_n    = (r_count > COUNT_W'(MAX_STOPS)) ? COUNT_W'(MAX_STOPS) : r_count;
        w_last = w_n - 1'b1;
    end

    logic w_en;
    logic r_out_valid;
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    // stage a: input register
    logic                    r_a_valid;
    logic signed [POS_W-1:0] r_a_sample;

    // stage b: compares
    logic                    r_b_valid;
    logic signed [POS_W-1:0] r_b_sample;
    logic [REG_STOPS-1:0]    r_b_le;
    logic                    r_b_lt_last;
    logic [REG_STOPS-1:0]    n_b_le;

    always_comb begin
        for (int k = 0; k < REG_STOPS; k++) n_b_le[k] = (r_a_sample <= w_pos[k]);
    end

    // stage c: pick the span and form numerator and denominator
    logic        r_c_valid;
    logic [32:0] r_c_num;
    logic [32:0] r_c_den;
    t_side       r_c_side;

    logic [32:0]           n_c_num;
    logic [32:0]           n_c_den;
    t_side                 n_c_side;
    logic [STOP_IDX_W-1:0] w_hi;
    logic                  w_found;

    always_comb begin
        w_hi    = w_last;
        w_found = 1'b0;
        for (int k = 1; k < REG_STOPS; k++) begin
            if (!w_found && r_b_le[k] && (STOP_IDX_W'(k) < w_n)) begin
                w_hi    = STOP_IDX_W'(k);
                w_found = 1'b1;
            end
        end
        n_c_num       = '0;
        n_c_den       = 33'd1;
        n_c_side.zero = 1'b0;
        n_c_side.c0   = '0;
        n_c_side.c1   = '0;
        priority if (w_n == '0) begin
            n_c_side.zero = 1'b1;
        end else if (r_b_le[0] || w_n == COUNT_W'(1)) begin
            n_c_side.c0 = r_stop[0][RGB_W-1:0];
            n_c_side.c1 = r_stop[0][RGB_W-1:0];
        end else if (!r_b_lt_last) begin
            n_c_side.c0 = r_stop[w_last][RGB_W-1:0];
            n_c_side.c1 = r_stop[w_last][RGB_W-1:0];
        end else begin
            n_c_num = {r_b_sample[POS_W-1], r_b_sample}
                    - {w_pos[w_hi - 1'b1][POS_W-1], w_pos[w_hi - 1'b1]};
            n_c_den = {w_pos[w_hi][POS_W-1], w_pos[w_hi]}
                    - {w_pos[w_hi - 1'b1][POS_W-1], w_pos[w_hi - 1'b1]};
            n_c_side.c0 = r_stop[w_hi - 1'b1][RGB_W-1:0];
            n_c_side.c1 = r_stop[w_hi][RGB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
        if (w_en) begin
            r_a_sample  <= i_sample;
            r_b_sample  <= r_a_sample;
            r_b_le      <= n_b_le;
            r_b_lt_last <= (r_a_sample < w_pos[w_last]);
            r_c_num     <= n_c_num;
            r_c_den     <= n_c_den;
            r_c_side    <= n_c_side;
        end
    end

    logic                   w_d_valid;
    logic [FRACTION_BITS:0] w_d_quot;
    t_side                  w_d_side;

    crip_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_valid),
        .i_num   (r_c_num),
        .i_den   (r_c_den),
        .i_side  (r_c_side),
        .o_valid (w_d_valid),
        .o_quot  (w_d_quot),
        .o_side  (w_d_side)
    );

    // blend: c0 + (c1 - c0) * frac, rounded half up
    function automatic logic [7:0] blend(input logic [7:0] c0, input logic [7:0] c1,
                                         input logic [FRACTION_BITS:0] frac);
        logic signed [ACC_W-1:0] acc;
        acc = (ACC_W'($signed({1'b0, c0})) <<< FRACTION_BITS)
            + (ACC_W'($signed({1'b0, c1})) - ACC_W'($signed({1'b0, c0})))
              * ACC_W'($signed({1'b0, frac}))
            + (ACC_W'(1) <<< (FRACTION_BITS - 1));
        return acc[FRACTION_BITS +: 8];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
        if (w_en) begin
            o_red       <= blend(w_d_side.c0[23:16], w_d_side.c1[23:16], w_d_quot);
            o_green     <= blend(w_d_side.c0[15:8], w_d_side.c1[15:8], w_d_quot);
            o_blue      <= blend(w_d_side.c0[7:0], w_d_side.c1[7:0], w_d_quot);
            o_alpha_out <= w_d_side.zero ? '0 : r_alpha;
        end
    end

    assign o_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d_valid |-> w_d_quot <= ((FRACTION_BITS+1)'(1) << FRACTION_BITS))
        else $error("fraction above one");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d_valid && w_d_side.zero && w_en |=>
            o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_alpha_out == 8'd0)
        else $error("no-stop word not transparent");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_c_valid && !w_d_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

// File: sim/tb_color_ramp_interpolator.sv
`timescale 1ns / 1ps

module tb_color_ramp_interpolator;
    import crip_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 5;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic signed [31:0] i_sample = 0;
    logic o_valid;
    logic i_ready = 0;
    logic [7:0] o_red, o_green, o_blue, o_alpha_out;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_STOP_COUNT;
    logic [STOP_W-1:0] i_cfg_data = 0;

    color_ramp_interpolator uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor registers
    logic [COUNT_W-1:0] ramp_count;
    logic [ALPHA_W-1:0] ramp_alpha;
    t_stop ramp_stop [REG_STOPS];

    t_rgba color_queue [$];
    int errors = 0;
    longint cycles = 0;
    bit hold_sink = 0;
    bit sink_burst = 0;

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic signed [31:0] stop_position(input int k);
        return ramp_stop[k][55:24];
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] c0, input logic [7:0] c1,
                                         input longint frac);
        longint acc;
        acc = longint'(c0) * (64'sd1 << FRAC) + (longint'(c1) - longint'(c0)) * frac
              + (64'sd1 << (FRAC - 1));
        if (acc < 0) acc = 0;
        acc = acc / (64'sd1 << FRAC);
        if (acc > 255) acc = 255;
        return acc[7:0];
    endfunction

    function automatic t_rgba map_sample(input logic signed [31:0] s);
        int n, i;
        logic [23:0] rgb, a, b;
        longint p0, p1, frac;
        t_rgba r;
        n = (ramp_count > 6) ? 6 : ramp_count;
        if (n == 0) return '0;
        if (s <= stop_position(0)) begin
            rgb = ramp_stop[0][23:0];
        end else if (s >= stop_position(n - 1)) begin
            rgb = ramp_stop[n-1][23:0];
        end else begin
            i = n - 1;
            for (int k = 1; k < n; k++) begin
                if (s <= stop_position(k)) begin
                    i = k;
                    break;
                end
            end
            p0 = stop_position(i - 1);
            p1 = stop_position(i);
            a = ramp_stop[i-1][23:0];
            b = ramp_stop[i][23:0];
            frac = 0;
            if (p1 != p0 && s > p0) frac = ((longint'(s) - p0) << FRAC) / (p1 - p0);
            if (frac > (64'sd1 << FRAC)) frac = 64'sd1 << FRAC;
            rgb = {blend(a[23:16], b[23:16], frac), blend(a[15:8], b[15:8], frac),
                   blend(a[7:0], b[7:0], frac)};
        end
        r.red = rgb[23:16];
        r.green = rgb[15:8];
        r.blue = rgb[7:0];
        r.alpha = ramp_alpha;
        return r;
    endfunction

    task automatic send_sample(input logic signed [31:0] s);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        color_queue.push_back(map_sample(s));
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [STOP_W-1:0] data);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_STOP_COUNT: ramp_count = data[2:0];
            REG_ALPHA_LEVEL: ramp_alpha = data[7:0];
            default: ramp_stop[int'(idx) - 2] = data;
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (color_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic hold_receiver(input int len);
        hold_sink = 1;
        repeat (len) @(posedge i_clk);
        hold_sink = 0;
    endtask

    function automatic logic signed [31:0] near_stop();
        int k;
        k = $urandom_range(0, 5);
        return stop_position(k) + $signed($urandom_range(0, 8)) - 4;
    endfunction

    function automatic logic signed [31:0] random_sample();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return near_stop();
            default: return $signed($urandom_range(0, 32'h0001_4000)) - 32'sh2000;
        endcase
    endfunction

    // output side: random stalls, plus one long hold-off stretch
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_ready <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (color_queue.size() == 0) begin
                    $display("unexpected word at %0t", $time);
                    errors++;
                end else begin
                    t_rgba want;
                    want = color_queue.pop_front();
                    if (o_red != want.red) report("red", o_red, want.red);
                    if (o_green != want.green) report("green", o_green, want.green);
                    if (o_blue != want.blue) report("blue", o_blue, want.blue);
                    if (o_alpha_out != want.alpha) report("alpha", o_alpha_out, want.alpha);
                end
            end
            if (hold_sink) begin
                i_ready <= 0;
            end else if (sink_burst) begin
                i_ready <= 1;
            end else begin
                i_ready <= ($urandom_range(0, 3) == 0) ? 0 : 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_reset_ramp();
        logic signed [31:0] pts [$];
        pts = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh4000, 32'sh8000, 32'hc000,
                32'sh1_0000, 32'sh2000, 32'sh6001, 32'shffff, -1, 1};
        foreach (pts[j]) send_sample(pts[j]);
        drain();
    endtask

    task automatic test_stop_counts();
        for (int c = 0; c <= 7; c++) begin
            drain();
            write_reg(REG_STOP_COUNT, STOP_W'(c));
            send_sample(32'sh8000);
            send_sample(32'sh1_8000);
        end
        drain();
    endtask

    task automatic test_registers();
        for (int r = 0; r < 12; r++) begin
            logic signed [31:0] pos;
            write_reg(REG_STOP_COUNT, STOP_W'($urandom_range(0, 7)));
            write_reg(REG_ALPHA_LEVEL,
                      STOP_W'((r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255)));
            pos = (r % 3 == 0) ? 32'sh8000_0000 : $signed($urandom_range(0, 16'hffff)) - 32'sh8000;
            for (int k = 0; k < REG_STOPS; k++) begin
                logic [23:0] rgb;
                rgb = (r == 2) ? 24'hffffff : (r == 3) ? 24'h0 : $urandom();
                if (r % 4 == 1) pos = $urandom();  // unordered stops
                else if (k == REG_STOPS - 1 && r % 3 == 0) pos = 32'sh7fff_ffff;
                else pos = pos + $signed($urandom_range(0, 16'h4000));
                write_reg(t_cfg_reg'(int'(REG_STOP_ZERO) + k), {pos, rgb});
            end
            for (int j = 0; j < 130; j++) send_sample(random_sample());
            drain();
        end
    endtask

    task automatic test_back_pressure();
        sink_burst = 0;
        @(posedge i_clk);
        fork
            hold_receiver(200);
        join_none
        for (int j = 0; j < 60; j++) send_sample(random_sample());
        sink_burst = 1;
        for (int j = 0; j < 40; j++) send_sample(random_sample());
        sink_burst = 0;
        drain();
    endtask

    initial begin
        ramp_count = COUNT_RESET;
        ramp_alpha = ALPHA_RESET;
        for (int k = 0; k < REG_STOPS; k++) ramp_stop[k] = STOP_RESET[k];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_reset_ramp();
        test_stop_counts();
        test_registers();
        test_back_pressure();
        if (errors == 0 && color_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/crip_pkg.sv
hdl/crip_divider.sv
hdl/color_ramp_interpolator.sv
sim/tb_color_ramp_interpolator.sv
